### hdl/rgb_scan_pkg.sv
// Package with the beat types, state codes and constants of the RGB matrix scan engine.
`timescale 1ns / 1ps

package rgb_scan_pkg;

	localparam int CHAN_W = 5;
	localparam int COLOR_W = 3 * CHAN_W;
	localparam int ROW_SEL_W = 4;
	localparam int POS_W = 16;

	localparam logic [CHAN_W-1:0] CHAN_MASK = 5'h1f;
	localparam logic [CHAN_W-1:0] BRIGHT_LAST = 5'd30;
	localparam logic [CHAN_W-1:0] BRIGHT_RESET = 5'd30;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic kind;
		logic signed [POS_W-1:0] x_pos;
		logic signed [POS_W-1:0] y_pos;
		logic [15:0] pixel_color;
	} cmd_t;

	typedef struct packed {
		logic red_upper;
		logic green_upper;
		logic blue_upper;
		logic red_lower;
		logic green_lower;
		logic blue_lower;
		logic [ROW_SEL_W-1:0] row_select;
		logic last_column;
	} res_t;

	function automatic logic [CHAN_W-1:0] reverse5(input logic [CHAN_W-1:0] c);
		logic [CHAN_W-1:0] r;
		for (int i = 0; i < CHAN_W; i++) begin
			r[i] = c[CHAN_W-1-i];
		end
		return r;
	endfunction

endpackage

### hdl/rgb_matrix_scan_pwm.sv
// Top level of the RGB matrix scan engine: frame store, clearing pass and column scan sequencer.
`timescale 1ns / 1ps

//  channel  | direction | handshake          | beat
//  command  | in        | start, busy        | cmd   (kind, x_pos, y_pos, pixel_color)
//  result   | out       | res_valid          | res   (six color bits, row_select, last_column)
//
// A pixel write does not raise busy, so writes may follow back to back.
// A tick starts a column scan, one column read from each half store per cycle, with the
// results registered in stage s1 and then in the result register behind the column counter.
// After reset a clearing pass zeroes all HALF_ROWS * PANEL_WIDTH entries of both half stores;
// busy is high during it. Results cannot be stalled and appear as one beat per cycle.
module rgb_matrix_scan_pwm
	import rgb_scan_pkg::*;
#(
	parameter int PANEL_WIDTH = 64,
	parameter int HALF_ROWS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic res_valid,
	output res_t res
);

	localparam int DEPTH = HALF_ROWS * PANEL_WIDTH;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COL_W = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
	localparam int ROW_W = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;

	state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CHAN_W-1:0] bright_q;

	logic accept, tick, wr_ok, wr_lower, we_upper, we_lower, issue, clr_done, col_done;
	logic [ROW_W-1:0] wr_row, row_next;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [COLOR_W-1:0] wr_data;

	logic [COLOR_W-1:0] upper_mem [DEPTH];
	logic [COLOR_W-1:0] lower_mem [DEPTH];

	logic valid_s1, last_s1;
	logic [ROW_W-1:0] row_s1;
	logic [CHAN_W-1:0] cmp_s1;
	logic [COLOR_W-1:0] upper_s1, lower_s1;

	logic res_valid_q;
	res_t res_q;

	assign accept = start && !busy;
	assign tick = accept && (cmd.kind == KIND_TICK);
	assign clr_done = (clr_q == ADDR_W'(DEPTH - 1));
	assign col_done = (col_q == COL_W'(PANEL_WIDTH - 1));

	assign wr_ok = !cmd.x_pos[POS_W-1] && !cmd.y_pos[POS_W-1]
		&& (cmd.x_pos < POS_W'(PANEL_WIDTH)) && (cmd.y_pos < POS_W'(2 * HALF_ROWS));
	assign wr_lower = (cmd.y_pos >= POS_W'(HALF_ROWS));
	assign wr_row = wr_lower ? ROW_W'(cmd.y_pos - POS_W'(HALF_ROWS)) : ROW_W'(cmd.y_pos);
	assign row_next = (row_q == ROW_W'(HALF_ROWS - 1)) ? '0 : row_q + 1'b1;

	always_comb begin
		state_d = state_q;
		busy = 1'b1;
		issue = 1'b0;
		we_upper = 1'b0;
		we_lower = 1'b0;
		wr_addr = ADDR_W'(wr_row) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(cmd.x_pos);
		wr_data = cmd.pixel_color[COLOR_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				we_upper = 1'b1;
				we_lower = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start && cmd.kind == KIND_WRITE && wr_ok) begin
					we_upper = !wr_lower;
					we_lower = wr_lower;
				end
				if (tick) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (col_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rd_addr = ADDR_W'(row_q) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			col_q <= '0;
			row_q <= ROW_W'(HALF_ROWS - 1);
			bright_q <= BRIGHT_RESET;
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (tick) begin
				col_q <= '0;
				row_q <= row_next;
				if (row_next == '0) begin
					bright_q <= (bright_q == BRIGHT_LAST) ? '0 : bright_q + 1'b1;
				end
			end else if (issue) begin
				col_q <= col_q + 1'b1;
			end
			valid_s1 <= issue;
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= col_done;
		row_s1 <= row_q;
		cmp_s1 <= reverse5(bright_q);
	end

	always_ff @(posedge clk) begin
		if (we_upper) begin
			upper_mem[wr_addr] <= wr_data;
		end
		upper_s1 <= upper_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (we_lower) begin
			lower_mem[wr_addr] <= wr_data;
		end
		lower_s1 <= lower_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		res_q.red_upper <= (upper_s1[CHAN_W-1:0] & CHAN_MASK) > cmp_s1;
		res_q.green_upper <= upper_s1[2*CHAN_W-1:CHAN_W] > cmp_s1;
		res_q.blue_upper <= upper_s1[3*CHAN_W-1:2*CHAN_W] > cmp_s1;
		res_q.red_lower <= (lower_s1[CHAN_W-1:0] & CHAN_MASK) > cmp_s1;
		res_q.green_lower <= lower_s1[2*CHAN_W-1:CHAN_W] > cmp_s1;
		res_q.blue_lower <= lower_s1[3*CHAN_W-1:2*CHAN_W] > cmp_s1;
		res_q.row_select <= ROW_SEL_W'(row_s1);
		res_q.last_column <= last_s1;
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule
